[rtl/bsts_pkg.sv]
// Shared definitions for the bilinear scanline texture sampler.
// Holds row geometry, opcodes, register indexes, the command struct and the lane blend.
// No dependencies.
package bsts_pkg;

    localparam int ROW_TEXELS = 1024;
    localparam int IDX_W      = $clog2(ROW_TEXELS);

    localparam logic [31:0] LANE_MASK  = 32'h00ff00ff;
    localparam logic [31:0] HALF_TEXEL = 32'h00008000;
    localparam logic [31:0] BYTE_MASK  = 32'h000000ff;
    localparam logic [31:0] ALPHA_BITS = 32'hff000000;
    localparam logic [31:0] COORD_CAP  = 32'(ROW_TEXELS * 65536 - 1);

    localparam logic [1:0] OP_WRITE_UPPER = 2'd0;
    localparam logic [1:0] OP_WRITE_LOWER = 2'd1;
    localparam logic [1:0] OP_BEGIN       = 2'd2;
    localparam logic [1:0] OP_SAMPLE      = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INCREMENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COORDINATE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BLEND_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_FILTER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_OPAQUE     = 3'd4;

    // Commands from the sequencer to the datapath; at most one stage strobe is high.
    typedef struct packed {
        logic accept;
        logic calc;
        logic read;
        logic vert;
        logic horz;
    } cmd_t;

    // Two-lane byte interpolation with 32-bit wraparound.
    function automatic logic [31:0] lerp_lanes(input logic [31:0] a, input logic [31:0] b,
                                               input logic [7:0] w);
        logic [31:0] lo_a;
        logic [31:0] hi_a;
        logic [31:0] lo_d;
        logic [31:0] hi_d;
        logic [31:0] lo_p;
        logic [31:0] hi_p;
        logic [31:0] lo;
        logic [31:0] hi;
        lo_a = a & LANE_MASK;
        hi_a = (a >> 8) & LANE_MASK;
        lo_d = (b & LANE_MASK) - lo_a;
        hi_d = ((b >> 8) & LANE_MASK) - hi_a;
        lo_p = lo_d * {24'd0, w};
        hi_p = hi_d * {24'd0, w};
        lo   = (lo_a + (lo_p >> 8)) & LANE_MASK;
        hi   = ((hi_a + (hi_p >> 8)) << 8) & ~LANE_MASK;
        return lo | hi;
    endfunction

endpackage

[rtl/bsts_if.sv]
// Channel interfaces of the texture sampler: input items, result pixels, register writes.
// Depends on bsts_pkg for the register index width.
interface bsts_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [9:0]         texel_index;
    logic [31:0]        texel_value;
    logic signed [31:0] start_coordinate;

    modport source (output valid, output opcode, output texel_index, output texel_value,
                    output start_coordinate, input ready);
    modport sink (input valid, input opcode, input texel_index, input texel_value,
                  input start_coordinate, output ready);
endinterface

interface bsts_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface bsts_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bsts_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/bsts_ctrl.sv]
// Sample sequencer of the texture sampler: input handshake, stage strobes, output valid.
// Depends on bsts_pkg for the command struct and opcodes.
module bsts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     in_opcode,
    output logic           in_ready,
    input  logic           out_ready,
    output logic           out_valid,
    output bsts_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_VERT = 3'd3;
    localparam logic [2:0] S_HORZ = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.accept     = in_valid && in_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_opcode == bsts_pkg::OP_SAMPLE)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_VERT;
            end
            S_VERT:
            begin
                cmd.vert   = 1'b1;
                state_next = S_HORZ;
            end
            S_HORZ:
            begin
                // The finished pixel waits here until the output register is free.
                if (slot_free)
                begin
                    cmd.horz       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.calc, cmd.read, cmd.vert, cmd.horz}))
        else $error("more than one stage strobe active");

    a_horz_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.horz |=> out_valid_reg)
        else $error("blended pixel not presented");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HORZ && out_valid_reg && !out_ready) |=> state_reg == S_HORZ)
        else $error("pixel overwrote an untaken result");

    a_calc_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc |=> cmd.read)
        else $error("row read did not follow coordinate stage");

endmodule

[rtl/bsts_dp.sv]
// Datapath of the texture sampler: registers, row stores, coordinate clamp and lane blends.
// Depends on bsts_pkg for constants, the command struct and the blend function.
module bsts_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bsts_pkg::cmd_t                 cmd,
    input  logic [1:0]                     opcode,
    input  logic [9:0]                     texel_index,
    input  logic [31:0]                    texel_value,
    input  logic signed [31:0]             start_coordinate,
    input  logic                           cfg_write,
    input  logic [bsts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output logic [31:0]                    pixel
);

    logic [31:0] step_reg;
    logic [25:0] limit_reg;
    logic [7:0]  weight_reg;
    logic        linear_reg;
    logic        opaque_reg;
    logic [31:0] acc_reg;

    logic [31:0] upper_mem [bsts_pkg::ROW_TEXELS];
    logic [31:0] lower_mem [bsts_pkg::ROW_TEXELS];

    logic [bsts_pkg::IDX_W-1:0] li_reg;
    logic [bsts_pkg::IDX_W-1:0] ri_reg;
    logic [7:0]                 frac_reg;
    logic [31:0]                ul_reg;
    logic [31:0]                ll_reg;
    logic [31:0]                ur_reg;
    logic [31:0]                lr_reg;
    logic [31:0]                a_reg;
    logic [31:0]                b_reg;
    logic [31:0]                pixel_reg;

    logic [31:0]                lim_eff;
    logic [31:0]                left_raw;
    logic [31:0]                right_raw;
    logic [31:0]                left_c;
    logic [31:0]                right_c;
    logic [bsts_pkg::IDX_W-1:0] li_next;
    logic [bsts_pkg::IDX_W-1:0] ri_next;
    logic [31:0]                pixel_next;
    logic                       index_ok;

    function automatic logic [31:0] clamp_coord(input logic [31:0] v, input logic [31:0] lim);
        if (v[31])
            return 32'd0;
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [bsts_pkg::IDX_W-1:0] row_index(input logic [31:0] c);
        logic [15:0] ip;
        ip = c[31:16];
        if (32'(ip) < bsts_pkg::ROW_TEXELS)
            return ip[bsts_pkg::IDX_W-1:0];
        return bsts_pkg::IDX_W'(bsts_pkg::ROW_TEXELS - 1);
    endfunction

    always_comb
    begin
        lim_eff   = ({6'd0, limit_reg} > bsts_pkg::COORD_CAP) ? bsts_pkg::COORD_CAP
                                                                : {6'd0, limit_reg};
        left_raw  = acc_reg - (linear_reg ? bsts_pkg::HALF_TEXEL : 32'd0);
        right_raw = acc_reg + bsts_pkg::HALF_TEXEL;
        left_c    = clamp_coord(left_raw, lim_eff);
        right_c   = clamp_coord(right_raw, lim_eff);
        li_next   = row_index(left_c);
        ri_next   = row_index(right_c);
        index_ok  = 32'(texel_index) < bsts_pkg::ROW_TEXELS;
    end

    always_comb
    begin
        if (linear_reg)
            pixel_next = bsts_pkg::lerp_lanes(a_reg, b_reg, frac_reg);
        else
            pixel_next = ul_reg;
        if (opaque_reg)
            pixel_next = pixel_next | bsts_pkg::ALPHA_BITS;
    end

    assign pixel = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 32'h0001_0000;
            limit_reg  <= '0;
            weight_reg <= '0;
            linear_reg <= 1'b0;
            opaque_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bsts_pkg::REG_STEP_INCREMENT:   step_reg   <= cfg_data;
                bsts_pkg::REG_COORDINATE_LIMIT: limit_reg  <= cfg_data[25:0];
                bsts_pkg::REG_ROW_BLEND_WEIGHT: weight_reg <= cfg_data[7:0];
                bsts_pkg::REG_LINEAR_FILTER:    linear_reg <= cfg_data[0];
                bsts_pkg::REG_FORCE_OPAQUE:     opaque_reg <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (cmd.accept && opcode == bsts_pkg::OP_BEGIN)
            acc_reg <= start_coordinate;
        else if (cmd.calc)
            acc_reg <= acc_reg + step_reg;
    end

    // Row stores: one write port, two registered read ports each.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && index_ok && opcode == bsts_pkg::OP_WRITE_UPPER)
            upper_mem[texel_index[bsts_pkg::IDX_W-1:0]] <= texel_value;
        if (cmd.accept && index_ok && opcode == bsts_pkg::OP_WRITE_LOWER)
            lower_mem[texel_index[bsts_pkg::IDX_W-1:0]] <= texel_value;
        if (cmd.read)
        begin
            ul_reg <= upper_mem[li_reg];
            ll_reg <= lower_mem[li_reg];
            ur_reg <= upper_mem[ri_reg];
            lr_reg <= lower_mem[ri_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            li_reg   <= li_next;
            ri_reg   <= ri_next;
            frac_reg <= 8'((left_c >> 8) & bsts_pkg::BYTE_MASK);
        end
        if (cmd.vert)
        begin
            a_reg <= bsts_pkg::lerp_lanes(ul_reg, ll_reg, weight_reg);
            b_reg <= bsts_pkg::lerp_lanes(ur_reg, lr_reg, weight_reg);
        end
        if (cmd.horz)
            pixel_reg <= pixel_next;
    end

endmodule

[rtl/bilinear_scanline_texture_sampler.sv]
// Write and begin requests leave the sequencer idle, ready for the next request. A sample
// request holds the input through the accepting cycle, then the coordinate clamp, a registered
// read of both row stores at the left and right texel, the vertical blend and the horizontal
// blend, one register stage each of the sample sequencer. Its pixel becomes valid as the
// sequencer returns to idle, where the next request can be taken. The pixel sits in an output
// register while the next request is accepted; a later sample waits in its last stage only if
// that register is still full.
// The row stores are not cleared after reset, and configuration writes are always taken.
// Depends on bsts_pkg, the channel interfaces, bsts_ctrl and bsts_dp.
module bilinear_scanline_texture_sampler (
    input  logic   clk,
    input  logic   rst_n,
    bsts_item_if.sink    item,
    bsts_pixel_if.source result,
    bsts_cfg_if.sink     cfg
);

    bsts_pkg::cmd_t cmd;

    assign cfg.ready = 1'b1;

    bsts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_opcode (item.opcode),
        .in_ready  (item.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .cmd       (cmd)
    );

    bsts_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .opcode           (item.opcode),
        .texel_index      (item.texel_index),
        .texel_value      (item.texel_value),
        .start_coordinate (item.start_coordinate),
        .cfg_write        (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .pixel            (result.pixel)
    );

endmodule

[verif/sampler_pixel_check.sv]
// Pixel checker for the bilinear scanline texture sampler: watches the request, result and
// register channels, predicts every sampled pixel and compares it with what comes out.
// Depends on bsts_pkg and the channel interfaces in bsts_if.
module sampler_pixel_check
    import bsts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bsts_item_if  item,
    bsts_pixel_if result,
    bsts_cfg_if   cfg,
    output int    pixel_errors,
    output int    pixels_pending
);

    localparam logic [31:0] CLAMP_CEILING = 32'(ROW_TEXELS * 65536 - 1);

    logic [31:0] upper_row [ROW_TEXELS];
    logic [31:0] lower_row [ROW_TEXELS];
    logic [31:0] coord_acc;
    logic [31:0] step_inc;
    logic [25:0] coord_lim;
    logic [7:0]  row_weight;
    logic        linear_on;
    logic        opaque_on;
    logic [31:0] expected_pixels [$];

    // Blend each byte lane pair of a toward b by w/256, lane arithmetic wrapping at 32 bits.
    function automatic logic [31:0] blend_texels(input logic [31:0] a, input logic [31:0] b,
                                                 input logic [7:0] w);
        logic [31:0] base;
        logic [31:0] diff;
        logic [31:0] prod;
        logic [31:0] mixed;
        int          lane;
        mixed = '0;
        for (lane = 0; lane < 2; lane++)
        begin
            base  = (a >> (8 * lane)) & 32'h00ff00ff;
            diff  = ((b >> (8 * lane)) & 32'h00ff00ff) - base;
            prod  = diff * {24'd0, w};
            mixed = mixed | (((base + (prod >> 8)) & 32'h00ff00ff) << (8 * lane));
        end
        return mixed;
    endfunction

    function automatic logic [31:0] clamp_coord(input logic [31:0] c, input logic [31:0] lim);
        if (c[31])
            return '0;
        return (c > lim) ? lim : c;
    endfunction

    function automatic int texel_at(input logic [31:0] c);
        logic [31:0] whole;
        whole = c >> 16;
        return (whole < ROW_TEXELS) ? int'(whole) : ROW_TEXELS - 1;
    endfunction

    function automatic logic [31:0] predict_pixel();
        logic [31:0] lim;
        logic [31:0] left_c;
        logic [31:0] px;
        int          li;
        int          ri;
        lim    = ({6'd0, coord_lim} > CLAMP_CEILING) ? CLAMP_CEILING : {6'd0, coord_lim};
        left_c = clamp_coord(coord_acc - (linear_on ? 32'h00008000 : 32'h0), lim);
        li     = texel_at(left_c);
        px     = upper_row[li];
        if (linear_on)
        begin
            ri = texel_at(clamp_coord(coord_acc + 32'h00008000, lim));
            px = blend_texels(blend_texels(upper_row[li], lower_row[li], row_weight),
                              blend_texels(upper_row[ri], lower_row[ri], row_weight),
                              left_c[15:8]);
        end
        if (opaque_on)
            px[31:24] = 8'hff;
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_acc      <= '0;
            step_inc       <= 32'h00010000;
            coord_lim      <= '0;
            row_weight     <= '0;
            linear_on      <= 1'b0;
            opaque_on      <= 1'b0;
            pixel_errors   <= 0;
            pixels_pending <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (pixel_errors < 10)
                        $display("pixel %08h arrived with no sample request waiting",
                                 result.pixel);
                    pixel_errors <= pixel_errors + 1;
                end
                else if (result.pixel !== expected_pixels[0])
                begin
                    if (pixel_errors < 10)
                        $display("pixel mismatch: expected %08h, got %08h",
                                 expected_pixels[0], result.pixel);
                    pixel_errors <= pixel_errors + 1;
                    void'(expected_pixels.pop_front());
                end
                else
                    void'(expected_pixels.pop_front());
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_STEP_INCREMENT:   step_inc   <= cfg.data;
                    REG_COORDINATE_LIMIT: coord_lim  <= cfg.data[25:0];
                    REG_ROW_BLEND_WEIGHT: row_weight <= cfg.data[7:0];
                    REG_LINEAR_FILTER:    linear_on  <= cfg.data[0];
                    REG_FORCE_OPAQUE:     opaque_on  <= cfg.data[0];
                    default: ;
                endcase
            end

            if (item.valid && item.ready)
            begin
                case (item.opcode)
                    OP_WRITE_UPPER:
                        if (item.texel_index < ROW_TEXELS)
                            upper_row[item.texel_index] = item.texel_value;
                    OP_WRITE_LOWER:
                        if (item.texel_index < ROW_TEXELS)
                            lower_row[item.texel_index] = item.texel_value;
                    OP_BEGIN:
                        coord_acc <= item.start_coordinate;
                    default:
                    begin
                        expected_pixels.push_back(predict_pixel());
                        coord_acc <= coord_acc + step_inc;
                    end
                endcase
            end

            pixels_pending <= expected_pixels.size();
        end
    end

endmodule

[verif/bilinear_scanline_texture_sampler_tb.sv]
// Testbench top for the bilinear scanline texture sampler: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on bsts_pkg, bsts_if, the sampler RTL and sampler_pixel_check.
module bilinear_scanline_texture_sampler_tb;
    import bsts_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 175;
    localparam int LOADED_TEXELS = 192;
    localparam logic [25:0] LOADED_LIMIT = 26'(LOADED_TEXELS * 65536 - 1);

    logic        clk;
    logic        rst_n;
    int          pixel_errors;
    int          pixels_pending;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_ticket;
    int          cycle_count = 0;
    logic [31:0] cur_limit;

    bsts_item_if  item_ch ();
    bsts_pixel_if pixel_ch ();
    bsts_cfg_if   cfg_ch ();

    bilinear_scanline_texture_sampler DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (pixel_ch),
        .cfg    (cfg_ch)
    );

    sampler_pixel_check pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .result         (pixel_ch),
        .cfg            (cfg_ch),
        .pixel_errors   (pixel_errors),
        .pixels_pending (pixels_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result back-pressure; a long hold-off starts whenever the ticket count moves on.
    initial
    begin
        int hold_left;
        int tickets_served;
        hold_left      = 0;
        tickets_served = 0;
        pixel_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != tickets_served)
            begin
                tickets_served = hold_ticket;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_ch.ready <= 1'b0;
            end
            else
                pixel_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [9:0] idx,
                             input logic [31:0] val, input logic [31:0] start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.opcode           <= op;
        item_ch.texel_index      <= idx;
        item_ch.texel_value      <= val;
        item_ch.start_coordinate <= start;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic sample_pixel();
        send_item(OP_SAMPLE, 10'($urandom), $urandom, $urandom);
    endtask

    task automatic begin_line(input logic [31:0] start);
        send_item(OP_BEGIN, 10'($urandom), $urandom, start);
    endtask

    // Drain every pending pixel and let the pipeline empty before touching registers.
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (index == REG_COORDINATE_LIMIT)
            cur_limit = {6'd0, data[25:0]};
    endtask

    task automatic apply_settings(input logic [31:0] step, input logic [25:0] limit,
                                  input logic [7:0] weight, input logic linear,
                                  input logic opaque, input logic stray_write);
        write_reg(REG_STEP_INCREMENT, step);
        write_reg(REG_COORDINATE_LIMIT, {6'($urandom_range(63)), limit});
        write_reg(REG_ROW_BLEND_WEIGHT, {24'($urandom), weight});
        write_reg(REG_LINEAR_FILTER, {31'($urandom), linear});
        write_reg(REG_FORCE_OPAQUE, {31'($urandom), opaque});
        // Indexes past the last register must leave every setting alone.
        if (stray_write)
            write_reg(CFG_IDX_W'($urandom_range(REG_FORCE_OPAQUE + 1, 7)), $urandom);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Limits stay inside the loaded texels so every lookup hits a written entry.
    task automatic shuffle_settings();
        logic [31:0] step;
        logic [25:0] limit;
        logic [7:0]  weight;
        case ($urandom_range(7))
            0:       step = '0;
            1:       step = 32'hffffffff;
            2:       step = $urandom;
            3:       step = -$urandom_range(1, 32'h20000);
            default: step = $urandom_range(32'h400, 32'h28000);
        endcase
        case ($urandom_range(5))
            0:       limit = '0;
            1:       limit = LOADED_LIMIT;
            2:       limit = 26'($urandom_range(0, 32'(LOADED_LIMIT)));
            default: limit = 26'($urandom_range(32'h10000, 32'h600000));
        endcase
        case ($urandom_range(4))
            0:       weight = 8'h00;
            1:       weight = 8'hff;
            default: weight = 8'($urandom);
        endcase
        apply_settings(step, limit, weight, 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    function automatic logic [31:0] pick_start();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return -$urandom_range(0, 32'h30000);
            2:       return cur_limit - $urandom_range(0, 32'h30000);
            default: return $urandom_range(0, cur_limit + 32'h20000);
        endcase
    endfunction

    // Mostly scanlines of random length, with texel rewrites and stray samples between them.
    task automatic run_phase(input int count);
        int sent;
        int burst;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_item($urandom_range(1) ? OP_WRITE_LOWER : OP_WRITE_UPPER,
                          10'($urandom), $urandom, $urandom);
                sent++;
            end
            else if (pick < 12)
            begin
                sample_pixel();
                sent++;
            end
            else
            begin
                begin_line(pick_start());
                burst = $urandom_range(1, 24);
                repeat (burst) sample_pixel();
                sent += burst + 1;
            end
        end
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        send_idle_pct            = 0;
        stall_pct                = 0;
        hold_ticket              = 0;
        cur_limit                = '0;
        item_ch.valid            = 1'b0;
        item_ch.opcode           = OP_WRITE_UPPER;
        item_ch.texel_index      = '0;
        item_ch.texel_value      = '0;
        item_ch.start_coordinate = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = REG_STEP_INCREMENT;
        cfg_ch.data              = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the low texels of both rows and the last one. The full-limit checks below
        // only reach the two end texels, and every other limit stays inside the low ones.
        for (int i = 0; i < ROW_TEXELS; i++)
        begin
            if (i < LOADED_TEXELS || i == ROW_TEXELS - 1)
            begin
                send_item(OP_WRITE_UPPER, 10'(i), (i == 0) ? 32'h0 :
                          (i == ROW_TEXELS - 1) ? 32'hffffffff : $urandom, $urandom);
                send_item(OP_WRITE_LOWER, 10'(i), (i == 0) ? 32'hffffffff :
                          (i == ROW_TEXELS - 1) ? 32'h0 : $urandom, $urandom);
            end
        end

        // Reset settings: nearest mode with a zero limit pins every sample to texel zero.
        begin_line(32'h0);
        sample_pixel();
        sample_pixel();
        begin_line(32'h7fffffff);
        sample_pixel();
        settle();

        // Bilinear at full weight and limit, opaque alpha, a step of minus one.
        apply_settings(32'hffffffff, 26'h3ffffff, 8'hff, 1'b1, 1'b1, 1'b1);
        begin_line(32'h0);
        sample_pixel();
        sample_pixel();
        begin_line(32'h7fffffff);
        sample_pixel();
        begin_line(32'h80000000);
        sample_pixel();
        begin_line(32'h03ff8000);
        sample_pixel();
        settle();

        // A zero step repeats the same coordinate; zero weight keeps the upper row.
        apply_settings(32'h0, 26'h0054321, 8'h00, 1'b1, 1'b0, 1'b0);
        begin_line(32'h00023456);
        sample_pixel();
        sample_pixel();
        send_item(OP_WRITE_UPPER, 10'd0, 32'hffffffff, $urandom);
        send_item(OP_WRITE_LOWER, 10'd0, 32'h00000000, $urandom);
        begin_line(32'h0);
        sample_pixel();
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            shuffle_settings();
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 45;
                end
                default:
                begin
                    send_idle_pct = 30;
                    stall_pct     = 30;
                end
            endcase
            // Hold results back while requests keep coming so the input side stalls.
            if (phase == 4)
                hold_ticket++;
            run_phase(PHASE_ITEMS);
            settle();
        end

        stall_pct = 0;
        settle();
        if (pixel_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
